@@ rtl/core/tes_pkg.sv @@
// ----------------------------------------------------------------------------
// tes_pkg
// Shared types, constants and helper functions for the terminal escape
// sanitizer: word formats, the phase encoding and the normal-phase byte rule.
// ----------------------------------------------------------------------------
package tes_pkg;

    // Widths fixed by the word formats.
    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 16;

    // Default depth of the queue between the front and back parts.
    localparam int QUEUE_DEPTH = 4;

    // Reset value of the sequence cap register.
    localparam logic [COUNT_W-1:0] CAP_RESET = 16'd4096;

    // Item opcodes.
    localparam logic OP_DATA   = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    // Byte codes that steer the filter.
    localparam logic [BYTE_W-1:0] CH_BEL       = 8'h07;
    localparam logic [BYTE_W-1:0] CH_TAB       = 8'h09;
    localparam logic [BYTE_W-1:0] CH_LF        = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_ESC       = 8'h1B;
    localparam logic [BYTE_W-1:0] CH_SPACE     = 8'h20;
    localparam logic [BYTE_W-1:0] CH_FINAL_LO  = 8'h40;
    localparam logic [BYTE_W-1:0] CH_DCS       = 8'h50;
    localparam logic [BYTE_W-1:0] CH_SOS       = 8'h58;
    localparam logic [BYTE_W-1:0] CH_CSI       = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_ST        = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_OSC       = 8'h5D;
    localparam logic [BYTE_W-1:0] CH_PM        = 8'h5E;
    localparam logic [BYTE_W-1:0] CH_APC       = 8'h5F;
    localparam logic [BYTE_W-1:0] CH_FINAL_HI  = 8'h7E;
    localparam logic [BYTE_W-1:0] CH_DEL       = 8'h7F;
    localparam logic [BYTE_W-1:0] CH_C1_LO     = 8'h80;
    localparam logic [BYTE_W-1:0] CH_C1_HI     = 8'h9F;
    localparam logic [BYTE_W-1:0] CH_C1_PREFIX = 8'hC2;

    // Input word.
    typedef struct packed {
        logic              op;
        logic [BYTE_W-1:0] data_byte;
    } item_t;

    // Output word.
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last;
    } result_t;

    // Filter phase, one-hot.
    typedef enum logic [5:0] {
        PH_NORMAL = 6'b000001,
        PH_SAWC2  = 6'b000010,
        PH_ESC    = 6'b000100,
        PH_CSI    = 6'b001000,
        PH_STR    = 6'b010000,
        PH_STRESC = 6'b100000
    } phase_t;

    // One classified input byte as queued for the back part.
    typedef struct packed {
        logic              emit_c2;
        logic              emit_b;
        logic [BYTE_W-1:0] data_byte;
    } entry_t;

    // Push request from the front part into the queue.
    typedef struct packed {
        logic   valid;
        entry_t entry;
    } push_t;

    // Queue status seen by the back part.
    typedef struct packed {
        logic   empty;
        entry_t head;
    } queue_stat_t;

    // Outcome of handling a byte from the normal phase.
    typedef struct packed {
        phase_t             phase;
        logic [COUNT_W-1:0] count;
        logic               emit;
    } nstep_t;

    // True for a byte that passes straight through in the normal phase.
    function automatic logic passes(input logic [BYTE_W-1:0] b);
        logic ok;
        begin
            ok = 1'b1;
            if (b == CH_LF || b == CH_TAB)
            begin
                ok = 1'b1;
            end
            else if (b < CH_SPACE || b == CH_DEL)
            begin
                ok = 1'b0;
            end
            return ok;
        end
    endfunction

    // True for the byte after ESC that opens a string sequence.
    function automatic logic string_intro(input logic [BYTE_W-1:0] b);
        return (b == CH_DCS) || (b == CH_OSC) || (b == CH_SOS) ||
               (b == CH_PM)  || (b == CH_APC);
    endfunction

    // Handles a byte from the normal phase with the given running count.
    function automatic nstep_t normal_step(input logic [BYTE_W-1:0] b,
                                           input logic [COUNT_W-1:0] cnt);
        nstep_t s;
        begin
            s.phase = PH_NORMAL;
            s.count = cnt;
            s.emit  = 1'b0;
            if (b == CH_ESC)
            begin
                s.phase = PH_ESC;
                s.count = COUNT_W'(1);
            end
            else if (b == CH_C1_PREFIX)
            begin
                s.phase = PH_SAWC2;
            end
            else
            begin
                s.emit = passes(b);
            end
            return s;
        end
    endfunction

endpackage

@@ rtl/core/terminal_escape_sanitizer.sv @@
// ----------------------------------------------------------------------------
// terminal_escape_sanitizer
// Filters a terminal byte stream, removing control bytes and escape
// sequences while passing printable text.
// ----------------------------------------------------------------------------
// The block takes one input word per clock cycle while item_stall is low. Each
// word is classified combinationally by the front part, which holds the filter
// phase and sequence count; words that produce output enter a queue of
// QUEUE_DEPTH entries and the back part drains it through a registered output
// stage. A word gives zero, one or two output words; a word giving two keeps
// the output busy for both, and the queue absorbs that until it is full, when
// item_stall rises. The output register loads the head entry once it is free.
// The sequence cap register is written through cfg_wr_en/cfg_wr_data and
// should only be changed while the block is idle. No clearing pass follows
// reset.
module terminal_escape_sanitizer
#(
    parameter int QUEUE_DEPTH = tes_pkg::QUEUE_DEPTH
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    output logic                         item_stall,
    input  tes_pkg::item_t               item,
    output logic                         result_valid,
    input  logic                         result_stall,
    output tes_pkg::result_t             result,
    input  logic                         cfg_wr_en,
    input  logic [tes_pkg::COUNT_W-1:0]  cfg_wr_data
);

    logic                 accept;
    logic                 full;
    logic                 pop;
    tes_pkg::push_t       push;
    tes_pkg::queue_stat_t stat;

    // An input word is taken whenever the queue has room.
    assign item_stall = full;
    assign accept     = item_valid && !full;

    tes_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .item        (item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .push        (push)
    );

    tes_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .full  (full),
        .stat  (stat)
    );

    tes_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .stat         (stat),
        .pop          (pop),
        .result_valid (result_valid),
        .result       (result),
        .result_stall (result_stall)
    );

endmodule

@@ rtl/core/tes_front.sv @@
// ----------------------------------------------------------------------------
// tes_front
// Front part: holds the filter phase, the sequence count and the cap
// register, classifies each accepted word and queues the bytes to emit.
// ----------------------------------------------------------------------------
module tes_front
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  tes_pkg::item_t               item,
    input  logic                         cfg_wr_en,
    input  logic [tes_pkg::COUNT_W-1:0]  cfg_wr_data,
    output tes_pkg::push_t               push
);

    tes_pkg::phase_t               phase_reg;
    tes_pkg::phase_t               phase_next;
    logic [tes_pkg::COUNT_W-1:0]   count_reg;
    logic [tes_pkg::COUNT_W-1:0]   count_next;
    logic [tes_pkg::COUNT_W-1:0]   cap_reg;
    logic [tes_pkg::COUNT_W-1:0]   cap_next;

    logic [tes_pkg::BYTE_W-1:0]    b;
    logic [tes_pkg::COUNT_W-1:0]   cnt_inc;
    logic                          cap_hit;
    logic                          emit_c2;
    logic                          emit_b;
    tes_pkg::nstep_t               nb_keep;
    tes_pkg::nstep_t               nb_zero;

    assign b       = item.data_byte;
    assign cnt_inc = count_reg + tes_pkg::COUNT_W'(1);
    assign cap_hit = (cnt_inc >= cap_reg);
    assign nb_keep = tes_pkg::normal_step(b, count_reg);
    assign nb_zero = tes_pkg::normal_step(b, '0);

    // Cap register update from the configuration port.
    assign cap_next = cfg_wr_en ? cfg_wr_data : cap_reg;

    // Phase transition and emit decision for the current word.
    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        emit_c2    = 1'b0;
        emit_b     = 1'b0;
        if (item.op == tes_pkg::OP_FINISH)
        begin
            phase_next = tes_pkg::PH_NORMAL;
            count_next = '0;
        end
        else
        begin
            case (phase_reg)
                tes_pkg::PH_SAWC2:
                begin
                    if (b >= tes_pkg::CH_C1_LO && b <= tes_pkg::CH_C1_HI)
                    begin
                        phase_next = tes_pkg::PH_NORMAL;
                    end
                    else
                    begin
                        emit_c2    = 1'b1;
                        phase_next = nb_keep.phase;
                        count_next = nb_keep.count;
                        emit_b     = nb_keep.emit;
                    end
                end
                tes_pkg::PH_ESC:
                begin
                    if (b == tes_pkg::CH_CSI || tes_pkg::string_intro(b))
                    begin
                        if (cap_hit)
                        begin
                            phase_next = tes_pkg::PH_NORMAL;
                            count_next = '0;
                        end
                        else
                        begin
                            phase_next = (b == tes_pkg::CH_CSI) ? tes_pkg::PH_CSI
                                                                : tes_pkg::PH_STR;
                            count_next = cnt_inc;
                        end
                    end
                    else if (b >= tes_pkg::CH_SPACE && b <= tes_pkg::CH_FINAL_HI)
                    begin
                        phase_next = tes_pkg::PH_NORMAL;
                        count_next = '0;
                    end
                    else
                    begin
                        // Malformed escape: drop the ESC, handle the byte afresh.
                        phase_next = nb_zero.phase;
                        count_next = nb_zero.count;
                        emit_b     = nb_zero.emit;
                    end
                end
                tes_pkg::PH_CSI:
                begin
                    if ((b >= tes_pkg::CH_FINAL_LO && b <= tes_pkg::CH_FINAL_HI) ||
                        cap_hit)
                    begin
                        phase_next = tes_pkg::PH_NORMAL;
                        count_next = '0;
                    end
                    else
                    begin
                        count_next = cnt_inc;
                    end
                end
                tes_pkg::PH_STR:
                begin
                    if (b == tes_pkg::CH_BEL || cap_hit)
                    begin
                        phase_next = tes_pkg::PH_NORMAL;
                        count_next = '0;
                    end
                    else
                    begin
                        count_next = cnt_inc;
                        if (b == tes_pkg::CH_ESC)
                        begin
                            phase_next = tes_pkg::PH_STRESC;
                        end
                    end
                end
                tes_pkg::PH_STRESC:
                begin
                    if (b == tes_pkg::CH_ST || cap_hit)
                    begin
                        phase_next = tes_pkg::PH_NORMAL;
                        count_next = '0;
                    end
                    else
                    begin
                        phase_next = tes_pkg::PH_STR;
                        count_next = cnt_inc;
                    end
                end
                default:
                begin
                    phase_next = nb_keep.phase;
                    count_next = nb_keep.count;
                    emit_b     = nb_keep.emit;
                end
            endcase
        end
    end

    // Queue request: only words that produce output are queued.
    always_comb
    begin
        push.valid           = accept && (item.op == tes_pkg::OP_DATA) &&
                               (emit_c2 || emit_b);
        push.entry.emit_c2   = emit_c2;
        push.entry.emit_b    = emit_b;
        push.entry.data_byte = b;
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= tes_pkg::PH_NORMAL;
            count_reg <= '0;
            cap_reg   <= tes_pkg::CAP_RESET;
        end
        else
        begin
            cap_reg <= cap_next;
            if (accept)
            begin
                phase_reg <= phase_next;
                count_reg <= count_next;
            end
        end
    end

endmodule

@@ rtl/core/tes_queue.sv @@
// ----------------------------------------------------------------------------
// tes_queue
// Short first-in first-out queue of classified entries between the front
// and back parts, so that each side can stall on its own.
// ----------------------------------------------------------------------------
module tes_queue
#(
    parameter int DEPTH = tes_pkg::QUEUE_DEPTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  tes_pkg::push_t       push,
    input  logic                 pop,
    output logic                 full,
    output tes_pkg::queue_stat_t stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tes_pkg::entry_t   store_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  fill_reg;
    logic [CNT_W-1:0]  fill_next;
    logic              do_push;
    logic              do_pop;

    assign full       = (fill_reg == CNT_W'(DEPTH));
    assign stat.empty = (fill_reg == '0);
    assign stat.head  = store_reg[rd_ptr_reg];

    assign do_push = push.valid && !full;
    assign do_pop  = pop && !stat.empty;

    // Pointer and fill level bookkeeping.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                                                            : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                                                            : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - CNT_W'(1);
        end
    end

    // Entry storage; no reset needed for payload.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= push.entry;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

@@ rtl/core/tes_back.sv @@
// ----------------------------------------------------------------------------
// tes_back
// Back part: takes queued entries and turns each into one or two output
// words through a registered output stage.
// ----------------------------------------------------------------------------
module tes_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  tes_pkg::queue_stat_t stat,
    output logic                 pop,
    output logic                 result_valid,
    output tes_pkg::result_t     result,
    input  logic                 result_stall
);

    logic              out_valid_reg;
    logic              out_valid_next;
    tes_pkg::result_t  out_reg;
    tes_pkg::result_t  out_next;
    logic              half_reg;
    logic              half_next;
    logic              load;

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // The output register may be reloaded when empty or being taken.
    assign load = !out_valid_reg || !result_stall;

    // Split an entry into its held prefix byte and its own byte.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        half_next      = half_reg;
        pop            = 1'b0;
        if (load)
        begin
            out_valid_next = !stat.empty;
            if (!stat.empty)
            begin
                if (stat.head.emit_c2 && !half_reg)
                begin
                    out_next.out_byte = tes_pkg::CH_C1_PREFIX;
                    out_next.last     = !stat.head.emit_b;
                    if (stat.head.emit_b)
                    begin
                        half_next = 1'b1;
                    end
                    else
                    begin
                        pop = 1'b1;
                    end
                end
                else
                begin
                    out_next.out_byte = stat.head.data_byte;
                    out_next.last     = 1'b1;
                    half_next         = 1'b0;
                    pop               = 1'b1;
                end
            end
        end
    end

    // Output payload; no reset needed.
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            half_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            half_reg      <= half_next;
        end
    end

endmodule

@@ rtl/core/tes_checker.sv @@
// ----------------------------------------------------------------------------
// tes_checker
// Port-level checks on the sanitized output stream, bound to the top level.
// ----------------------------------------------------------------------------
module tes_checker
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         result_valid,
    input logic                         result_stall,
    input tes_pkg::result_t             result
);

    // A stalled output word holds until it is taken.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled output word changed");

    // Only the held prefix byte can be the first of two words.
    a_first_is_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last |-> result.out_byte == tes_pkg::CH_C1_PREFIX)
        else $error("non-final word is not the prefix byte");

    // The second word of a pair follows straight after the first is taken.
    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall && !result.last |=> result_valid && result.last)
        else $error("second word of a pair missing");

    // No C0 control byte other than LF or TAB (so no ESC), and no DEL, ever leaves the block.
    a_no_control: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !((result.out_byte < tes_pkg::CH_SPACE) &&
                           (result.out_byte != tes_pkg::CH_LF) &&
                           (result.out_byte != tes_pkg::CH_TAB)) &&
                         (result.out_byte != tes_pkg::CH_DEL))
        else $error("control byte in output stream");

endmodule

bind terminal_escape_sanitizer tes_checker u_tes_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
